>>> rtl/frae_pkg.sv
// Shared types, constants and address helpers for the file register ALU executor.
// Depends on nothing; the interfaces, the ALU, the top level and the testbench refer to it.
`timescale 1ns / 1ps

package frae_pkg;

    // Store geometry. FILE_DEPTH is a power of two; addresses wrap by truncation.
    localparam int FILE_DEPTH = 4096;
    localparam int ADDR_W     = $clog2(FILE_DEPTH);
    localparam int PC_WIDTH   = 21;

    // Fixed field widths of the request and the response.
    localparam int OP_W       = 4;
    localparam int FADDR_W    = 8;
    localparam int MADDR_W    = 12;
    localparam int DATA_W     = 8;
    localparam int NPC_W      = 21;
    localparam int FLAGS_W    = 5;

    // Special function registers, wrapped into the store.
    localparam logic [ADDR_W-1:0] ADDR_WREG   = ADDR_W'(12'hFE8 % FILE_DEPTH);
    localparam logic [ADDR_W-1:0] ADDR_STATUS = ADDR_W'(12'hFD8 % FILE_DEPTH);
    localparam logic [ADDR_W-1:0] ADDR_BSR    = ADDR_W'(12'hFE0 % FILE_DEPTH);

    // STATUS flag bits.
    localparam logic [FLAGS_W-1:0] FL_C   = 5'h01;
    localparam logic [FLAGS_W-1:0] FL_DC  = 5'h02;
    localparam logic [FLAGS_W-1:0] FL_Z   = 5'h04;
    localparam logic [FLAGS_W-1:0] FL_OV  = 5'h08;
    localparam logic [FLAGS_W-1:0] FL_N   = 5'h10;
    localparam logic [FLAGS_W-1:0] FL_ALL = FL_C | FL_DC | FL_Z | FL_OV | FL_N;
    localparam logic [FLAGS_W-1:0] FL_NZ  = FL_Z | FL_N;

    // Decoded byte-oriented operations.
    typedef enum logic [OP_W-1:0] {
        OP_ADDWFC = 4'd0,
        OP_ANDWF  = 4'd1,
        OP_CLRF   = 4'd2,
        OP_COMF   = 4'd3,
        OP_CPFSEQ = 4'd4,
        OP_CPFSLT = 4'd5,
        OP_CPFSGT = 4'd6,
        OP_DECF   = 4'd7,
        OP_DECFSZ = 4'd8,
        OP_DCFSNZ = 4'd9,
        OP_INCF   = 4'd10,
        OP_INCFSZ = 4'd11,
        OP_INFSNZ = 4'd12,
        OP_IORWF  = 4'd13,
        OP_MOVF   = 4'd14,
        OP_MOVFF  = 4'd15
    } t_op;

    // What the ALU hands back to the sequencer for one instruction.
    typedef struct packed {
        logic [DATA_W-1:0]  result;
        logic [FLAGS_W-1:0] mask;
        logic [FLAGS_W-1:0] flags;
        logic               skip;
        logic               write;
        logic               two_word;
    } t_alu_res;

    // Resolve an eight-bit file address through the access bank or the BSR.
    function automatic logic [ADDR_W-1:0] resolve_addr(
        input logic [FADDR_W-1:0] a,
        input logic               banked,
        input logic [3:0]         bsr_lo
    );
        logic [MADDR_W-1:0] full;
        begin
            if (banked) begin
                full = {bsr_lo, a};
            end else if (a[7]) begin
                full = {4'hF, a};
            end else begin
                full = {4'h0, a};
            end
            return full[ADDR_W-1:0];
        end
    endfunction

endpackage

>>> rtl/frae_if.sv
// Valid/ready channel interfaces for requests and responses of the executor.
// Depends on frae_pkg for the field widths.
`timescale 1ns / 1ps

interface frae_req_if;
    logic                             valid;
    logic                             ready;
    logic [frae_pkg::OP_W-1:0]        opcode;
    logic [frae_pkg::FADDR_W-1:0]     file_address;
    logic                             access_select;
    logic                             dest_select;
    logic [frae_pkg::MADDR_W-1:0]     move_source;
    logic [frae_pkg::MADDR_W-1:0]     move_target;

    modport source (
        output valid, opcode, file_address, access_select, dest_select,
               move_source, move_target,
        input  ready
    );
    modport sink (
        input  valid, opcode, file_address, access_select, dest_select,
               move_source, move_target,
        output ready
    );
endinterface

interface frae_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [frae_pkg::DATA_W-1:0]      result_value;
    logic [frae_pkg::NPC_W-1:0]       next_pc;
    logic [frae_pkg::FLAGS_W-1:0]     status_flags;
    logic                             skipped;

    modport source (
        output valid, result_value, next_pc, status_flags, skipped,
        input  ready
    );
    modport sink (
        input  valid, result_value, next_pc, status_flags, skipped,
        output ready
    );
endinterface

>>> rtl/frae_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read data.
// Depends on nothing; the executor uses it as its file store.
`timescale 1ns / 1ps

module frae_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/frae_alu.sv
// Byte ALU: result, flag mask and values, and skip decision of one instruction.
// Depends on frae_pkg for the operation codes and the result struct.
`timescale 1ns / 1ps

module frae_alu (
    input  frae_pkg::t_op                  i_op,
    input  logic [frae_pkg::DATA_W-1:0]    i_f,
    input  logic [frae_pkg::DATA_W-1:0]    i_w,
    input  logic                           i_carry,
    output frae_pkg::t_alu_res             o_res
);

    logic [frae_pkg::DATA_W:0]   sum;
    logic [4:0]                  nib_sum;
    logic [frae_pkg::DATA_W-1:0] dec_val;
    logic [frae_pkg::DATA_W-1:0] inc_val;

    // Adders; dec_val and inc_val are shared by several operations.
    assign sum     = {1'b0, i_f} + {1'b0, i_w} + {8'h00, i_carry};
    assign nib_sum = {1'b0, i_f[3:0]} + {1'b0, i_w[3:0]} + {4'h0, i_carry};
    assign dec_val = i_f - 8'h01;
    assign inc_val = i_f + 8'h01;

    // Zero and negative flags of a result byte.
    function automatic logic [frae_pkg::FLAGS_W-1:0] nz(input logic [frae_pkg::DATA_W-1:0] r);
        logic [frae_pkg::FLAGS_W-1:0] fl;
        begin
            fl = '0;
            if (r == 8'h00) begin
                fl = fl | frae_pkg::FL_Z;
            end
            if (r[7]) begin
                fl = fl | frae_pkg::FL_N;
            end
            return fl;
        end
    endfunction

    // Operation decode.
    always_comb begin
        o_res          = '0;
        o_res.write    = 1'b1;
        case (i_op)
            frae_pkg::OP_ADDWFC: begin
                o_res.result = sum[7:0];
                o_res.mask   = frae_pkg::FL_ALL;
                o_res.flags  = nz(sum[7:0]);
                if (sum[8]) begin
                    o_res.flags = o_res.flags | frae_pkg::FL_C;
                end
                if (nib_sum[4]) begin
                    o_res.flags = o_res.flags | frae_pkg::FL_DC;
                end
                if ((~(i_f[7] ^ i_w[7])) & (i_f[7] ^ sum[7])) begin
                    o_res.flags = o_res.flags | frae_pkg::FL_OV;
                end
            end
            frae_pkg::OP_ANDWF: begin
                o_res.result = i_f & i_w;
                o_res.mask   = frae_pkg::FL_NZ;
                o_res.flags  = nz(i_f & i_w);
            end
            frae_pkg::OP_CLRF: begin
                o_res.result = '0;
                o_res.mask   = frae_pkg::FL_Z;
                o_res.flags  = frae_pkg::FL_Z;
            end
            frae_pkg::OP_COMF: begin
                o_res.result = ~i_f;
                o_res.mask   = frae_pkg::FL_NZ;
                o_res.flags  = nz(~i_f);
            end
            frae_pkg::OP_CPFSEQ: begin
                o_res.result = i_f;
                o_res.write  = 1'b0;
                o_res.skip   = (i_f == i_w);
            end
            frae_pkg::OP_CPFSLT: begin
                o_res.result = i_f;
                o_res.write  = 1'b0;
                o_res.skip   = (i_f < i_w);
            end
            frae_pkg::OP_CPFSGT: begin
                o_res.result = i_f;
                o_res.write  = 1'b0;
                o_res.skip   = (i_f > i_w);
            end
            frae_pkg::OP_DECF: begin
                // Carry and digit carry mean no borrow here.
                o_res.result = dec_val;
                o_res.mask   = frae_pkg::FL_ALL;
                o_res.flags  = nz(dec_val);
                if (i_f != 8'h00) begin
                    o_res.flags = o_res.flags | frae_pkg::FL_C;
                end
                if (i_f[3:0] != 4'h0) begin
                    o_res.flags = o_res.flags | frae_pkg::FL_DC;
                end
                if (i_f == 8'h80) begin
                    o_res.flags = o_res.flags | frae_pkg::FL_OV;
                end
            end
            frae_pkg::OP_DECFSZ: begin
                o_res.result = dec_val;
                o_res.skip   = (dec_val == 8'h00);
            end
            frae_pkg::OP_DCFSNZ: begin
                o_res.result = dec_val;
                o_res.skip   = (dec_val != 8'h00);
            end
            frae_pkg::OP_INCF: begin
                o_res.result = inc_val;
                o_res.mask   = frae_pkg::FL_ALL;
                o_res.flags  = nz(inc_val);
                if (i_f == 8'hFF) begin
                    o_res.flags = o_res.flags | frae_pkg::FL_C;
                end
                if (i_f[3:0] == 4'hF) begin
                    o_res.flags = o_res.flags | frae_pkg::FL_DC;
                end
                if (i_f == 8'h7F) begin
                    o_res.flags = o_res.flags | frae_pkg::FL_OV;
                end
            end
            frae_pkg::OP_INCFSZ: begin
                o_res.result = inc_val;
                o_res.skip   = (inc_val == 8'h00);
            end
            frae_pkg::OP_INFSNZ: begin
                o_res.result = inc_val;
                o_res.skip   = (inc_val != 8'h00);
            end
            frae_pkg::OP_IORWF: begin
                o_res.result = i_f | i_w;
                o_res.mask   = frae_pkg::FL_NZ;
                o_res.flags  = nz(i_f | i_w);
            end
            frae_pkg::OP_MOVF: begin
                o_res.result = i_f;
                o_res.mask   = frae_pkg::FL_NZ;
                o_res.flags  = nz(i_f);
            end
            frae_pkg::OP_MOVFF: begin
                // The source byte arrives on the f operand.
                o_res.result   = i_f;
                o_res.two_word = 1'b1;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

>>> rtl/file_register_alu_executor_top.sv
// Top level of the file register ALU executor: sequencer, SFR copies and program counter.
// Depends on frae_pkg, frae_if, frae_ram and frae_alu.
`timescale 1ns / 1ps

// Each request executes one decoded byte-oriented instruction against a 4096-byte
// file store and returns one response with the written or compared byte, the new
// program counter, the STATUS flags and the skip bit. The file store read is issued
// with the request in the idle state (synchronous, registered read); the execute
// state computes and writes the result back, so a new request is taken only in the
// idle state and only while the response register is free or being emptied. After
// reset a clearing pass writes zero to all 4096 entries, one per cycle, and no
// request is taken until it is done. W, STATUS and BSR are kept in registers beside
// the store and serve every read of their addresses.
module file_register_alu_executor_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    frae_req_if.sink      i_req,
    frae_rsp_if.source    o_rsp
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state                            r_state;
    t_state                            n_state;
    logic [frae_pkg::ADDR_W-1:0]       r_clr_cnt;

    // Special function register copies and the program counter.
    logic [frae_pkg::DATA_W-1:0]       r_wreg;
    logic [frae_pkg::DATA_W-1:0]       r_status;
    logic [frae_pkg::DATA_W-1:0]       r_bsr;
    logic [frae_pkg::PC_WIDTH-1:0]     r_pc;
    logic [frae_pkg::DATA_W-1:0]       n_wreg;
    logic [frae_pkg::DATA_W-1:0]       n_status;
    logic [frae_pkg::DATA_W-1:0]       n_bsr;
    logic [frae_pkg::PC_WIDTH-1:0]     n_pc;

    // Instruction held between the read and the write-back cycle.
    frae_pkg::t_op                     r_op;
    logic [frae_pkg::ADDR_W-1:0]       r_f_addr;
    logic [frae_pkg::ADDR_W-1:0]       r_tgt_addr;
    logic [frae_pkg::ADDR_W-1:0]       r_rd_addr;
    logic                              r_to_f;

    // Response register.
    logic                              r_out_valid;
    logic [frae_pkg::DATA_W-1:0]       r_out_value;
    logic [frae_pkg::NPC_W-1:0]        r_out_pc;
    logic [frae_pkg::FLAGS_W-1:0]      r_out_flags;
    logic                              r_out_skip;

    logic                              accept;
    frae_pkg::t_op                     in_op;
    logic [frae_pkg::ADDR_W-1:0]       in_f_addr;
    logic [frae_pkg::ADDR_W-1:0]       in_rd_addr;
    logic [frae_pkg::DATA_W-1:0]       ram_q;
    logic [frae_pkg::DATA_W-1:0]       f_val;
    frae_pkg::t_alu_res                alu_res;
    logic [frae_pkg::ADDR_W-1:0]       where;
    logic [frae_pkg::DATA_W-1:0]       flag_status;
    logic                              exec;
    logic                              ram_we;
    logic [frae_pkg::ADDR_W-1:0]       ram_waddr;
    logic [frae_pkg::DATA_W-1:0]       ram_wdata;

    // Request handshake: idle, and the response register frees up by the next edge.
    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;
    assign exec        = (r_state == S_EXEC);

    // Address resolution for the read issued with the request.
    assign in_op      = frae_pkg::t_op'(i_req.opcode);
    assign in_f_addr  = frae_pkg::resolve_addr(i_req.file_address, i_req.access_select,
                                               r_bsr[3:0]);
    assign in_rd_addr = (in_op == frae_pkg::OP_MOVFF)
                      ? i_req.move_source[frae_pkg::ADDR_W-1:0] : in_f_addr;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == frae_pkg::ADDR_W'(frae_pkg::FILE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
        end
    end

    // Capture the instruction for its write-back cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= in_op;
            r_f_addr   <= in_f_addr;
            r_tgt_addr <= i_req.move_target[frae_pkg::ADDR_W-1:0];
            r_rd_addr  <= in_rd_addr;
            r_to_f     <= i_req.dest_select;
        end
    end

    // File store: the clearing pass owns the write port until it is done.
    assign ram_we    = (r_state == S_CLEAR) || (exec && alu_res.write);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_cnt : where;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : alu_res.result;

    frae_ram #(
        .DEPTH (frae_pkg::FILE_DEPTH),
        .WIDTH (frae_pkg::DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (in_rd_addr),
        .o_rdata (ram_q)
    );

    // Operand: the SFR copies stand in for their store entries.
    always_comb begin
        if (r_rd_addr == frae_pkg::ADDR_WREG) begin
            f_val = r_wreg;
        end else if (r_rd_addr == frae_pkg::ADDR_STATUS) begin
            f_val = r_status;
        end else if (r_rd_addr == frae_pkg::ADDR_BSR) begin
            f_val = r_bsr;
        end else begin
            f_val = ram_q;
        end
    end

    frae_alu u_alu (
        .i_op    (r_op),
        .i_f     (f_val),
        .i_w     (r_wreg),
        .i_carry (r_status[0]),
        .o_res   (alu_res)
    );

    // Destination of the write-back.
    always_comb begin
        if (r_op == frae_pkg::OP_MOVFF) begin
            where = r_tgt_addr;
        end else if (r_to_f || (r_op == frae_pkg::OP_CLRF)) begin
            where = r_f_addr;
        end else begin
            where = frae_pkg::ADDR_WREG;
        end
    end

    // Next SFR values: flags first, then the result write, which keeps the
    // new flags when the instruction affects any of them.
    always_comb begin
        flag_status = {r_status[7:5],
                       (r_status[4:0] & ~alu_res.mask) | (alu_res.flags & alu_res.mask)};
        n_status = flag_status;
        n_wreg   = r_wreg;
        n_bsr    = r_bsr;
        if (alu_res.write) begin
            if (where == frae_pkg::ADDR_STATUS) begin
                if (alu_res.mask != '0) begin
                    n_status = {alu_res.result[7:5], flag_status[4:0]};
                end else begin
                    n_status = alu_res.result;
                end
            end
            if (where == frae_pkg::ADDR_WREG) begin
                n_wreg = alu_res.result;
            end
            if (where == frae_pkg::ADDR_BSR) begin
                n_bsr = alu_res.result;
            end
        end
        if (alu_res.skip || alu_res.two_word) begin
            n_pc = r_pc + frae_pkg::PC_WIDTH'(4);
        end else begin
            n_pc = r_pc + frae_pkg::PC_WIDTH'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wreg   <= '0;
            r_status <= '0;
            r_bsr    <= '0;
            r_pc     <= '0;
        end else if (exec) begin
            r_wreg   <= n_wreg;
            r_status <= n_status;
            r_bsr    <= n_bsr;
            r_pc     <= n_pc;
        end
    end

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out_value <= alu_res.result;
            r_out_pc    <= frae_pkg::NPC_W'(n_pc);
            r_out_flags <= n_status[frae_pkg::FLAGS_W-1:0];
            r_out_skip  <= alu_res.skip;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out_value;
    assign o_rsp.next_pc      = r_out_pc;
    assign o_rsp.status_flags = r_out_flags;
    assign o_rsp.skipped      = r_out_skip;

endmodule

>>> sim/tb_file_register_alu_executor_top.sv
// Self-checking testbench for the file register ALU executor: drives requests, takes
// typed responses as given, predicts the rest from a shadow store and PC, and compares.
// Depends on frae_pkg, frae_if and the RTL of file_register_alu_executor_top.
`timescale 1ns / 1ps

module tb_file_register_alu_executor_top;
    import frae_pkg::*;

    // One decoded instruction as offered on the request channel.
    typedef struct packed {
        t_op                op;
        logic [FADDR_W-1:0] fa;
        logic               banked;
        logic               to_file;
        logic [MADDR_W-1:0] msrc;
        logic [MADDR_W-1:0] mtgt;
    } t_instr;

    // The fields of one response.
    typedef struct packed {
        logic [DATA_W-1:0]  result;
        logic [NPC_W-1:0]   pc;
        logic [FLAGS_W-1:0] flags;
        logic               skip;
    } t_outcome;

    // A directed row: the instruction and, where it is obvious, its typed response.
    typedef struct packed {
        t_instr   ins;
        logic     known;
        t_outcome resp;
    } t_row;

    localparam int DIRECTED_ROWS = 24;
    localparam int RANDOM_ITEMS  = 1276;
    localparam int SQUEEZE_AFTER = 300;
    localparam int SQUEEZE_LEN   = 400;

    // Starting from a cleared store, the first rows can be worked out by hand.
    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        '{'{OP_INCF,   8'h00, 1'b0, 1'b1, 12'h000, 12'h000}, 1'b1,
          '{8'h01, 21'd2,  5'h00, 1'b0}},
        '{'{OP_DECF,   8'h01, 1'b0, 1'b1, 12'h000, 12'h000}, 1'b1,
          '{8'hFF, 21'd4,  5'h10, 1'b0}},
        '{'{OP_INCF,   8'h01, 1'b0, 1'b1, 12'h000, 12'h000}, 1'b1,
          '{8'h00, 21'd6,  5'h07, 1'b0}},
        '{'{OP_CPFSEQ, 8'h01, 1'b0, 1'b0, 12'h000, 12'h000}, 1'b1,
          '{8'h00, 21'd10, 5'h07, 1'b1}},
        '{'{OP_CPFSGT, 8'h00, 1'b0, 1'b1, 12'h000, 12'h000}, 1'b1,
          '{8'h01, 21'd14, 5'h07, 1'b1}},
        '{'{OP_CPFSLT, 8'h00, 1'b0, 1'b0, 12'h000, 12'h000}, 1'b1,
          '{8'h01, 21'd16, 5'h07, 1'b0}},
        '{'{OP_DECFSZ, 8'h00, 1'b0, 1'b1, 12'h000, 12'h000}, 1'b1,
          '{8'h00, 21'd20, 5'h07, 1'b1}},
        '{'{OP_MOVFF,  8'h00, 1'b0, 1'b0, 12'hFFF, 12'h000}, 1'b1,
          '{8'h00, 21'd24, 5'h07, 1'b0}},
        '{'{OP_CLRF,   8'hFF, 1'b0, 1'b0, 12'h000, 12'h000}, 1'b1,
          '{8'h00, 21'd26, 5'h07, 1'b0}},
        // From here on the predictor supplies the response.
        '{'{OP_COMF,   8'hE8, 1'b0, 1'b1, 12'h000, 12'h000}, 1'b0, '0},
        '{'{OP_ADDWFC, 8'h00, 1'b0, 1'b0, 12'h000, 12'h000}, 1'b0, '0},
        '{'{OP_INCFSZ, 8'h7F, 1'b0, 1'b1, 12'h000, 12'h000}, 1'b0, '0},
        '{'{OP_INFSNZ, 8'h80, 1'b0, 1'b1, 12'h000, 12'h000}, 1'b0, '0},
        '{'{OP_DCFSNZ, 8'h02, 1'b0, 1'b0, 12'h000, 12'h000}, 1'b0, '0},
        '{'{OP_ANDWF,  8'hE8, 1'b0, 1'b1, 12'h000, 12'h000}, 1'b0, '0},
        '{'{OP_IORWF,  8'h03, 1'b0, 1'b0, 12'h000, 12'h000}, 1'b0, '0},
        '{'{OP_MOVF,   8'hE8, 1'b0, 1'b0, 12'h000, 12'h000}, 1'b0, '0},
        '{'{OP_COMF,   8'hD8, 1'b0, 1'b1, 12'h000, 12'h000}, 1'b0, '0},
        '{'{OP_MOVFF,  8'h00, 1'b0, 1'b0, 12'hFE8, 12'hFD8}, 1'b0, '0},
        '{'{OP_INCF,   8'hE0, 1'b0, 1'b1, 12'h000, 12'h000}, 1'b0, '0},
        '{'{OP_INCF,   8'h05, 1'b1, 1'b1, 12'h000, 12'h000}, 1'b0, '0},
        '{'{OP_MOVFF,  8'h00, 1'b0, 1'b0, 12'hFE8, 12'hFE0}, 1'b0, '0},
        '{'{OP_DECF,   8'hFF, 1'b1, 1'b1, 12'h000, 12'h000}, 1'b0, '0},
        '{'{OP_ADDWFC, 8'h80, 1'b0, 1'b1, 12'h000, 12'h000}, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    frae_req_if req_if ();
    frae_rsp_if rsp_if ();

    file_register_alu_executor_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the file store and program counter.
    logic [DATA_W-1:0] shadow_file [FILE_DEPTH];
    logic [NPC_W-1:0]  shadow_pc;

    t_outcome expected_outcomes [$];
    int       mismatch_count = 0;
    int       issued_count   = 0;
    int       burst_left     = 0;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit, well above the slowest legal run including the clearing pass.
    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
    endtask

    function automatic logic [FLAGS_W-1:0] zero_neg_flags(input logic [DATA_W-1:0] r);
        logic [FLAGS_W-1:0] fl;
        fl = '0;
        if (r == 8'h00) fl |= FL_Z;
        if (r[7]) fl |= FL_N;
        return fl;
    endfunction

    // Execute one instruction on the shadow state and return its response.
    function automatic t_outcome execute_instruction(input t_instr ins);
        logic [ADDR_W-1:0]  fa;
        logic [ADDR_W-1:0]  where;
        logic [DATA_W-1:0]  f;
        logic [DATA_W-1:0]  w;
        logic [DATA_W-1:0]  r;
        logic [FLAGS_W-1:0] mask;
        logic [FLAGS_W-1:0] fl;
        logic [8:0]         sum;
        logic               carry_in;
        logic               skip_next;
        logic               writes;
        logic [NPC_W-1:0]   step;
        t_outcome           o;
        begin
            if (ins.banked) begin
                fa = {shadow_file[ADDR_BSR][3:0], ins.fa};
            end else begin
                fa = {{4{ins.fa[7]}}, ins.fa};
            end
            f         = shadow_file[fa];
            w         = shadow_file[ADDR_WREG];
            carry_in  = shadow_file[ADDR_STATUS][0];
            r         = '0;
            mask      = '0;
            fl        = '0;
            skip_next = 1'b0;
            writes    = 1'b1;
            step      = 21'd2;
            where     = ins.to_file ? fa : ADDR_WREG;

            case (ins.op)
                OP_ADDWFC: begin
                    sum  = {1'b0, f} + {1'b0, w} + {8'h00, carry_in};
                    r    = sum[7:0];
                    mask = FL_ALL;
                    fl   = zero_neg_flags(r);
                    if (sum[8]) fl |= FL_C;
                    if (int'(f[3:0]) + int'(w[3:0]) + int'(carry_in) > 15) fl |= FL_DC;
                    if ((f[7] == w[7]) && (f[7] != r[7])) fl |= FL_OV;
                end
                OP_ANDWF: begin
                    r = f & w; mask = FL_NZ; fl = zero_neg_flags(r);
                end
                OP_CLRF: begin
                    r = '0; where = fa; mask = FL_Z; fl = FL_Z;
                end
                OP_COMF: begin
                    r = ~f; mask = FL_NZ; fl = zero_neg_flags(r);
                end
                OP_CPFSEQ: begin
                    r = f; writes = 1'b0; skip_next = (f == w);
                end
                OP_CPFSLT: begin
                    r = f; writes = 1'b0; skip_next = (f < w);
                end
                OP_CPFSGT: begin
                    r = f; writes = 1'b0; skip_next = (f > w);
                end
                OP_DECF: begin
                    // Carry and digit carry read as "no borrow" here.
                    r    = f - 8'h01;
                    mask = FL_ALL;
                    fl   = zero_neg_flags(r);
                    if (f != 8'h00) fl |= FL_C;
                    if (f[3:0] != 4'h0) fl |= FL_DC;
                    if (f == 8'h80) fl |= FL_OV;
                end
                OP_DECFSZ: begin
                    r = f - 8'h01; skip_next = (r == 8'h00);
                end
                OP_DCFSNZ: begin
                    r = f - 8'h01; skip_next = (r != 8'h00);
                end
                OP_INCF: begin
                    r    = f + 8'h01;
                    mask = FL_ALL;
                    fl   = zero_neg_flags(r);
                    if (f == 8'hFF) fl |= FL_C;
                    if (f[3:0] == 4'hF) fl |= FL_DC;
                    if (f == 8'h7F) fl |= FL_OV;
                end
                OP_INCFSZ: begin
                    r = f + 8'h01; skip_next = (r == 8'h00);
                end
                OP_INFSNZ: begin
                    r = f + 8'h01; skip_next = (r != 8'h00);
                end
                OP_IORWF: begin
                    r = f | w; mask = FL_NZ; fl = zero_neg_flags(r);
                end
                OP_MOVF: begin
                    r = f; mask = FL_NZ; fl = zero_neg_flags(r);
                end
                OP_MOVFF: begin
                    // Two-word move between full addresses.
                    r = shadow_file[ins.msrc]; where = ins.mtgt; step = 21'd4;
                end
            endcase

            if (mask != '0) begin
                shadow_file[ADDR_STATUS][4:0] =
                    (shadow_file[ADDR_STATUS][4:0] & ~mask) | (fl & mask);
            end
            // A flag-setting result written to STATUS leaves the new flags in place.
            if (writes) begin
                if (where == ADDR_STATUS && mask != '0) begin
                    shadow_file[where][7:5] = r[7:5];
                end else begin
                    shadow_file[where] = r;
                end
            end
            if (skip_next) step = 21'd4;
            shadow_pc = shadow_pc + step;

            o.result = r;
            o.pc     = shadow_pc;
            o.flags  = shadow_file[ADDR_STATUS][4:0];
            o.skip   = skip_next;
            return o;
        end
    endfunction

    // Full addresses that random instructions also touch, so moves feed the ALU.
    function automatic logic [MADDR_W-1:0] busy_address();
        case ($urandom_range(0, 4))
            0: return ADDR_WREG;
            1: return ADDR_STATUS;
            2: return ADDR_BSR;
            default: return {4'($urandom_range(0, 15)), 8'($urandom_range(0, 7))};
        endcase
    endfunction

    // Random instruction, biased toward the SFRs and a few hot file registers.
    function automatic t_instr draw_instruction();
        t_instr ins;
        int     pick;
        begin
            ins.op      = t_op'($urandom_range(0, 15));
            ins.to_file = 1'($urandom_range(0, 1));
            pick        = $urandom_range(0, 9);
            if (pick < 3) begin
                ins.banked = 1'b0;
                case ($urandom_range(0, 2))
                    0: ins.fa = 8'hE8;
                    1: ins.fa = 8'hD8;
                    default: ins.fa = 8'hE0;
                endcase
            end else if (pick < 7) begin
                ins.fa     = 8'($urandom_range(0, 7));
                ins.banked = 1'($urandom_range(0, 1));
            end else begin
                ins.fa     = 8'($urandom);
                ins.banked = 1'($urandom_range(0, 1));
            end
            ins.msrc = $urandom_range(0, 1) ? busy_address() : 12'($urandom);
            ins.mtgt = $urandom_range(0, 1) ? busy_address() : 12'($urandom);
            return ins;
        end
    endfunction

    // Offer one request, wait for it to be taken and record its expected response.
    task automatic offer_instruction(input t_instr ins, input logic known,
                                     input t_outcome typed_resp);
        t_outcome predicted;
        req_if.valid         <= 1'b1;
        req_if.opcode        <= ins.op;
        req_if.file_address  <= ins.fa;
        req_if.access_select <= ins.banked;
        req_if.dest_select   <= ins.to_file;
        req_if.move_source   <= ins.msrc;
        req_if.move_target   <= ins.mtgt;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predicted = execute_instruction(ins);
        expected_outcomes.push_back(known ? typed_resp : predicted);
        issued_count++;
    endtask

    // Bursts of back-to-back requests separated by random gaps.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(0, 6);
            if (gap != 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Reset, directed rows, random requests, then drain and report.
    initial begin : stimulus
        req_if.valid         <= 1'b0;
        req_if.opcode        <= '0;
        req_if.file_address  <= '0;
        req_if.access_select <= 1'b0;
        req_if.dest_select   <= 1'b0;
        req_if.move_source   <= '0;
        req_if.move_target   <= '0;
        i_rst_n              <= 1'b0;
        foreach (shadow_file[i]) shadow_file[i] = '0;
        shadow_pc = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            offer_instruction(DIRECTED[i].ins, DIRECTED[i].known, DIRECTED[i].resp);
            pace_sender();
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            offer_instruction(draw_instruction(), 1'b0, '0);
            pace_sender();
        end
        req_if.valid <= 1'b0;

        while (expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Response stall pattern; once, a long hold-off backs the block up into its input.
    initial begin : receiver
        int  mode;
        int  span;
        logic squeezed;
        squeezed = 1'b0;
        rsp_if.ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 120);
            repeat (span) begin
                @(posedge i_clk);
                if (!squeezed && issued_count >= SQUEEZE_AFTER) begin
                    squeezed = 1'b1;
                    rsp_if.ready <= 1'b0;
                    repeat (SQUEEZE_LEN) @(posedge i_clk);
                end
                case (mode)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= 1'($urandom_range(0, 1));
                    default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Compare every accepted response with the oldest expectation.
    always @(posedge i_clk) begin : response_check
        t_outcome want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_outcomes.size() == 0) begin
                report_mismatch("response arrived with none outstanding");
            end else begin
                want = expected_outcomes.pop_front();
                if (rsp_if.result_value !== want.result) begin
                    report_mismatch($sformatf("result_value got %02h want %02h",
                                              rsp_if.result_value, want.result));
                end
                if (rsp_if.next_pc !== want.pc) begin
                    report_mismatch($sformatf("next_pc got %06h want %06h",
                                              rsp_if.next_pc, want.pc));
                end
                if (rsp_if.status_flags !== want.flags) begin
                    report_mismatch($sformatf("status_flags got %02h want %02h",
                                              rsp_if.status_flags, want.flags));
                end
                if (rsp_if.skipped !== want.skip) begin
                    report_mismatch($sformatf("skipped got %0b want %0b",
                                              rsp_if.skipped, want.skip));
                end
            end
        end
    end

endmodule

>>> file_register_alu_executor_top.f
rtl/frae_pkg.sv
rtl/frae_if.sv
rtl/frae_ram.sv
rtl/frae_alu.sv
rtl/file_register_alu_executor_top.sv
sim/tb_file_register_alu_executor_top.sv
